@@ rtl/spkh_pkg.sv @@
`timescale 1ns / 1ps

package spkh_pkg;

    // Batch capacity in keys (2 .. 64)
    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam int KEY_W    = 64;
    localparam int TOKEN_W  = 32;
    localparam int COUNT_W  = 7;

    typedef struct packed {
        logic [KEY_W-1:0] pair_key;
        logic             batch_end;
    } spkh_in_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] left_token;
        logic [TOKEN_W-1:0] right_token;
        logic [COUNT_W-1:0] pair_count;
        logic               final_pair;
        logic               capacity_exceeded;
    } spkh_out_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SCAN,
        ST_EMIT
    } spkh_state_t;

endpackage

@@ rtl/sorted_pair_key_histogram_core.sv @@
`timescale 1ns / 1ps
// Sorted pair-key histogram.
// Input channel (in_valid/in_ready/in_data): one 64-bit key per transfer; the
// transfer with batch_end set closes the batch. Keys are taken at one per
// cycle while collecting and are written in arrival order into a key memory.
// Up to MAX_KEYS keys are kept; further keys are dropped and every result of
// that batch carries capacity_exceeded.
// Output channel (out_valid/out_ready/out_data): one transfer per distinct key,
// in ascending order, with the run count and final_pair on the largest key.
// After the closing key, each distinct key costs one pass over the key memory
// (one read per cycle on its single read port) plus a load of the output
// register. in_ready is low while draining.
// The output register holds a result until it is taken; while it waits, the
// next pass runs and then stalls. Once the final result is loaded the block
// returns to collecting, so the next batch may start while it is still held.
// Reset (rst_n low, asynchronous) empties the batch and the output register;
// the key memory is not cleared, a fill count marks its valid entries.

module sorted_pair_key_histogram_core
    import spkh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  spkh_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output spkh_out_t out_data
);

    spkh_state_t      state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             have_prev_reg, have_prev_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic             out_valid_reg, out_valid_next;

    logic [KEY_W-1:0] prev_reg, prev_next;
    logic [KEY_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    spkh_out_t        out_reg, out_next;

    logic             mem_we;
    logic             mem_re;
    logic [KEY_W-1:0] mem_rdata;
    logic [CNT_W-1:0] done_sum;
    logic             eligible;

    spkh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg[KEY_AW-1:0]),
        .wdata (in_data.pair_key),
        .re    (mem_re),
        .raddr (issue_reg[KEY_AW-1:0]),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Keys already reported plus the run now found
    assign done_sum = CNT_W'(emitted_reg + cnt_reg);
    // Only keys above the last emitted one take part in a pass
    assign eligible = !have_prev_reg || (mem_rdata > prev_reg);

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        have_prev_next = have_prev_reg;
        found_next     = found_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        prev_next      = prev_reg;
        min_next       = min_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    if (fill_reg < CNT_W'(MAX_KEYS))
                    begin
                        mem_we    = 1'b1;
                        fill_next = CNT_W'(fill_reg + 1'b1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_data.batch_end)
                    begin
                        state_next     = ST_SCAN;
                        issue_next     = '0;
                        have_prev_next = 1'b0;
                        found_next     = 1'b0;
                        emitted_next   = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue reads in order, fold returning data into the minimum
                if (issue_reg < fill_reg)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    issue_next    = CNT_W'(issue_reg + 1'b1);
                end
                if (rd_valid_reg && eligible)
                begin
                    if (!found_reg || (mem_rdata < min_reg))
                    begin
                        found_next = 1'b1;
                        min_next   = mem_rdata;
                        cnt_next   = CNT_W'(1);
                    end
                    else if (mem_rdata == min_reg)
                    begin
                        cnt_next = CNT_W'(cnt_reg + 1'b1);
                    end
                end
                if ((issue_reg == fill_reg) && !rd_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_next.left_token        = min_reg[KEY_W-1:TOKEN_W];
                    out_next.right_token       = min_reg[TOKEN_W-1:0];
                    out_next.pair_count        = COUNT_W'(cnt_reg);
                    out_next.final_pair        = (done_sum == fill_reg);
                    out_next.capacity_exceeded = drop_reg;
                    if (done_sum == fill_reg)
                    begin
                        state_next = ST_COLLECT;
                        fill_next  = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        prev_next      = min_reg;
                        have_prev_next = 1'b1;
                        found_next     = 1'b0;
                        issue_next     = '0;
                        emitted_next   = done_sum;
                    end
                end
            end

            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            found_reg     <= 1'b0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            have_prev_reg <= have_prev_next;
            found_reg     <= found_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        min_reg  <= min_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    // A pass always finds a key that is still to be reported
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> found_reg)
        else $error("emit without a found key");

    // Reported counts never run past the stored keys
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (done_sum <= fill_reg))
        else $error("run counts exceed stored keys");

    // Read data only returns for reads issued during a pass
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data outside a pass");

    // Fill count stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_KEYS))
        else $error("fill count above capacity");

endmodule

@@ rtl/spkh_ram.sv @@
`timescale 1ns / 1ps

module spkh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
